[hdl/mma_pkg.sv]
`timescale 1ns / 1ps

package mma_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W = 24;
  localparam int CHAN_W   = 3;
  localparam int LEN_W    = 5;

  // Default sizes of the per-channel state.
  localparam int NUM_CHANNELS_DEF = 8;
  localparam int WINDOW_MAX_DEF   = 16;

  // Window length after reset.
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic update;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic len_zero;
    logic len_one;
    logic div_done;
  } status_t;

endpackage

[hdl/mma_if.sv]
`timescale 1ns / 1ps

// Request channel carrying one new sample.
interface mma_in_if import mma_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CHAN_W-1:0]          channel;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

// Request channel carrying one average.
interface mma_out_if import mma_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] average;
  logic                       invalid;

  modport source (output valid, output average, output invalid, input ready);
  modport sink (input valid, input average, input invalid, output ready);
endinterface

[hdl/multichannel_moving_average.sv]
// A request with window length 0 or 1 goes from capture straight to the result register;
// any other passes the ring and sum stores and the bit-serial divider first.
// One request is in work at a time: a new one is taken only after the last result is loaded.
// SUM_W is 24 + clog2(WINDOW_MAX). Reset is synchronous, active high.
// After reset a clearing pass over all NUM_CHANNELS * WINDOW_MAX ring entries (128) zeroes the
// sample rings, sums and slots; no request is taken until it ends.
`timescale 1ns / 1ps

module multichannel_moving_average import mma_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  mma_in_if.sink           meas,
  mma_out_if.source        result
);

  cmd_t    cmd;
  status_t status;

  // Controller.
  mma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (meas.valid),
    .in_ready  (meas.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath with the ring store, sums and divider.
  mma_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .WINDOW_MAX   (WINDOW_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .channel   (meas.channel),
    .sample    (meas.sample),
    .cmd       (cmd),
    .status    (status),
    .average   (result.average),
    .invalid   (result.invalid)
  );

endmodule

[hdl/mma_ctrl.sv]
`timescale 1ns / 1ps

module mma_ctrl import mma_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_META   = 3'd2;
  localparam logic [2:0] S_RING   = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_PREP   = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_accept;
  logic       out_free;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Sequencing of one request through the datapath.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          cmd.capture = 1'b1;
          if (status.len_zero || status.len_one) begin
            state_next = S_OUT;
          end else begin
            state_next = S_META;
          end
        end
      end
      S_META: begin
        state_next = S_RING;
      end
      S_RING: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  // Only one request is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ready)
    else $error("request accepted while another was in work");

  // Bypass windows skip the memories and the divider.
  a_bypass_path: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (status.len_zero || status.len_one)) |=> (state == S_OUT))
    else $error("bypass request did not go straight to the result");

  // Leaving reset always begins with the clearing pass.
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> (state == S_CLEAR))
    else $error("clearing pass skipped after reset");
`endif

endmodule

[hdl/mma_datapath.sv]
`timescale 1ns / 1ps

module mma_datapath import mma_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [LEN_W-1:0]           cfg_wdata,
  input  logic [CHAN_W-1:0]          channel,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  cmd_t                       cmd,
  output status_t                    status,
  output logic signed [SAMPLE_W-1:0] average,
  output logic                       invalid
);

  localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int RING_DEPTH = NUM_CHANNELS * WINDOW_MAX;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int RA1        = RING_AW + 1;
  localparam int SUM_W      = SAMPLE_W + SLOT_W;
  localparam int META_W     = SLOT_W + SUM_W;
  localparam int CNT_W      = $clog2(SUM_W + 1);

  logic [LEN_W-1:0]           window_length;
  logic [LEN_W-1:0]           len_eff;
  logic [7:0]                 ch_tmp;
  logic [CH_W-1:0]            ch_mod;
  logic [CH_W-1:0]            ch_q;
  logic signed [SAMPLE_W-1:0] sample_q;

  logic [RING_AW-1:0]         clr_cnt;
  logic                       clr_meta;
  logic [RING_AW-1:0]         ring_addr;
  logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] ring_rd;
  logic [META_W-1:0]          meta_mem [NUM_CHANNELS];
  logic [META_W-1:0]          meta_rd;
  logic [SLOT_W-1:0]          slot_rd;
  logic signed [SUM_W-1:0]    sum_rd;
  logic signed [SUM_W-1:0]    sum_new;
  logic [SLOT_W:0]            slot_inc;
  logic [SLOT_W-1:0]          slot_next;
  logic signed [SUM_W-1:0]    acc;

  logic [LEN_W-1:0]           rem;
  logic [SUM_W-1:0]           quo;
  logic                       neg;
  logic [CNT_W-1:0]           div_cnt;
  logic [LEN_W:0]             rem_sh;
  logic [LEN_W:0]             diff;

  // Window length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  // Lengths beyond the ring size saturate.
  always_comb begin
    if (int'(window_length) > WINDOW_MAX) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = window_length;
    end
  end

  // Channel numbers wrap at the channel count by repeated subtraction.
  always_comb begin
    ch_tmp = 8'(channel);
    for (int k = 0; k < 8; k++) begin
      if (int'(ch_tmp) >= NUM_CHANNELS) begin
        ch_tmp = ch_tmp - 8'(NUM_CHANNELS);
      end
    end
    ch_mod = CH_W'(ch_tmp);
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_q     <= ch_mod;
      sample_q <= sample;
    end
  end

  // Clearing pass counter over the whole ring store.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign clr_meta = (int'(clr_cnt) < NUM_CHANNELS);

  // Per-channel slot and running sum.
  assign slot_rd = meta_rd[META_W-1:SUM_W];
  assign sum_rd  = meta_rd[SUM_W-1:0];

  assign ring_addr = RING_AW'(RA1'(ch_q) * RA1'(WINDOW_MAX) + RA1'(slot_rd));

  // Oldest sample leaves the sum, the new one enters; the slot advances.
  always_comb begin
    sum_new  = sum_rd - SUM_W'(ring_rd) + SUM_W'(sample_q);
    slot_inc = {1'b0, slot_rd} + 1'b1;
    if (int'(slot_inc) >= int'(len_eff)) begin
      slot_next = '0;
    end else begin
      slot_next = slot_inc[SLOT_W-1:0];
    end
  end

  // Ring store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      ring_mem[clr_cnt] <= '0;
    end else if (cmd.update) begin
      ring_mem[ring_addr] <= sample_q;
    end
    ring_rd <= ring_mem[ring_addr];
  end

  // Slot and sum store, one entry per channel.
  always_ff @(posedge clk) begin
    if (cmd.clear && clr_meta) begin
      meta_mem[clr_cnt[CH_W-1:0]] <= '0;
    end else if (cmd.update) begin
      meta_mem[ch_q] <= {slot_next, sum_new};
    end
    meta_rd <= meta_mem[ch_q];
  end

  // Updated sum feeds the divider.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      acc <= sum_new;
    end
  end

  // Restoring divider on the magnitude, one quotient bit per cycle.
  assign rem_sh = {rem, quo[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, len_eff};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= acc[SUM_W-1];
      quo <= acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!diff[LEN_W]) begin
        rem <= diff[LEN_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[LEN_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  // Step counter of the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= CNT_W'(SUM_W);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // Result register; the sign goes back on after the division.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (status.len_zero) begin
        average <= '0;
        invalid <= 1'b1;
      end else if (status.len_one) begin
        average <= sample_q;
        invalid <= 1'b0;
      end else begin
        average <= neg ? -quo[SAMPLE_W-1:0] : quo[SAMPLE_W-1:0];
        invalid <= 1'b0;
      end
    end
  end

  assign status.clear_last = (int'(clr_cnt) == RING_DEPTH - 1);
  assign status.len_zero   = (window_length == '0);
  assign status.len_one    = (len_eff == LEN_W'(1));
  assign status.div_done   = (div_cnt == '0);

`ifndef ASSERT_OFF
  // The partial remainder stays below the divisor during a division.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (div_cnt != '0) |-> (rem < len_eff))
    else $error("divider remainder out of range");

  // The step counter never runs past one quotient bit per sum bit.
  a_div_cnt_range: assert property (@(posedge clk) disable iff (rst)
    div_cnt <= CNT_W'(SUM_W))
    else $error("divider step counter out of range");

  // Ring writes stay inside the store.
  a_ring_addr: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (int'(ring_addr) < RING_DEPTH))
    else $error("ring address out of range");
`endif

endmodule

[dv/tb_multichannel_moving_average.sv]
`timescale 1ns / 1ps

module tb_multichannel_moving_average;
  import mma_pkg::*;

  localparam int SUM_W         = SAMPLE_W + 4;
  localparam int PHASE_ITEMS   = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 40;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  // One expected result of the block.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       invalid;
  } average_t;

  // Tracks every channel's ring and sum and holds the averages still owed by the block.
  class average_tracker;
    logic signed [SAMPLE_W-1:0] ring [NUM_CHANNELS_DEF][WINDOW_MAX_DEF];
    logic signed [SUM_W-1:0]    sum [NUM_CHANNELS_DEF];
    logic [3:0]                 slot [NUM_CHANNELS_DEF];
    logic [LEN_W-1:0]           window_len;
    average_t                   pending_averages[$];
    int                         errors;
    int                         zero_window_hits;
    int                         single_window_hits;

    function new();
      for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
        for (int w = 0; w < WINDOW_MAX_DEF; w++) ring[c][w] = '0;
        sum[c]  = '0;
        slot[c] = '0;
      end
      window_len         = LEN_RESET;
      errors             = 0;
      zero_window_hits   = 0;
      single_window_hits = 0;
    endfunction

    function void write_window(logic [LEN_W-1:0] value);
      window_len = value;
    endfunction

    // Update the channel's state for one accepted request and queue its average.
    function void note_sample(logic [CHAN_W-1:0] ch, logic signed [SAMPLE_W-1:0] s);
      average_t exp;
      int       len;
      int       next_slot;
      int       quotient;
      len = (window_len > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(window_len);
      exp.invalid = 1'b0;
      if (len == 0) begin
        exp.average = '0;
        exp.invalid = 1'b1;
        zero_window_hits++;
      end else if (len == 1) begin
        exp.average = s;
        single_window_hits++;
      end else begin
        sum[ch] = sum[ch] - ring[ch][slot[ch]] + s;
        ring[ch][slot[ch]] = s;
        next_slot = int'(slot[ch]) + 1;
        if (next_slot >= len) next_slot = 0;
        slot[ch] = next_slot[3:0];
        // Signed division in SystemVerilog truncates toward zero.
        quotient = int'(sum[ch]) / len;
        exp.average = quotient[SAMPLE_W-1:0];
      end
      pending_averages.push_back(exp);
    endfunction

    // Compare one delivered average with the oldest one owed.
    function void check_average(logic signed [SAMPLE_W-1:0] avg, logic inv);
      average_t exp;
      if (pending_averages.size() == 0) begin
        $error("average: none expected, got %0d (invalid %0b)", $signed(avg), inv);
        errors++;
        return;
      end
      exp = pending_averages.pop_front();
      if (avg !== exp.average) begin
        $error("average mismatch: expected %0d, got %0d", $signed(exp.average), $signed(avg));
        errors++;
      end
      if (inv !== exp.invalid) begin
        $error("invalid mismatch: expected %0b, got %0b", exp.invalid, inv);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  mma_in_if  meas ();
  mma_out_if result ();

  multichannel_moving_average dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .meas      (meas),
    .result    (result)
  );

  average_tracker tracker;
  bit             no_idle;
  bit             long_hold_req;
  bit             long_hold_done;
  int             idle_cycles;
  int             requests_seen;
  int             averages_seen;
  int             windows_written;

  always #4 clk = ~clk;

  // Watch both handshakes, feed the tracker, and stop a run that has stalled.
  always @(posedge clk) begin
    if (meas.valid && meas.ready) begin
      tracker.note_sample(meas.channel, meas.sample);
      requests_seen++;
    end
    if (result.valid && result.ready) begin
      tracker.check_average(result.average, result.invalid);
      averages_seen++;
    end
    if ((meas.valid && meas.ready) || (result.valid && result.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles.", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        result.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (!no_idle && $urandom_range(4) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(7, 1) - 1) @(negedge clk);
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // Offer one request and wait until the block takes it.
  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic signed [SAMPLE_W-1:0] s);
    @(negedge clk);
    if (!no_idle && $urandom_range(3) == 0) begin
      meas.valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(negedge clk);
    end
    meas.valid   <= 1'b1;
    meas.channel <= ch;
    meas.sample  <= s;
    do @(posedge clk); while (!meas.ready);
  endtask

  // Stop offering and wait until every owed average has come back.
  task automatic wait_drained();
    @(negedge clk);
    meas.valid <= 1'b0;
    while (tracker.pending_averages.size() != 0) @(posedge clk);
  endtask

  // Change the window length while the block is idle.
  task automatic set_window(input logic [LEN_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_window(value);
    windows_written++;
  endtask

  // Sample values weighted toward the extremes and toward small magnitudes.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return $signed(r[8:0]) - 9'sd256;
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  initial begin
    logic [LEN_W-1:0] phase_windows [12];
    logic [CHAN_W-1:0] ch;
    tracker         = new();
    no_idle         = 1'b0;
    long_hold_req   = 1'b0;
    long_hold_done  = 1'b0;
    idle_cycles     = 0;
    requests_seen   = 0;
    averages_seen   = 0;
    windows_written = 0;
    meas.valid      = 1'b0;
    meas.channel    = '0;
    meas.sample     = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Default window after reset, full-scale samples and a negative sum.
    send_sample(3'd0, SAMPLE_MAX);
    send_sample(3'd0, SAMPLE_MAX);
    send_sample(3'd7, SAMPLE_MIN);
    send_sample(3'd7, -24'sd1);

    // Small negative sums must truncate toward zero.
    set_window(5'd3);
    repeat (4) send_sample(3'd2, -24'sd1);

    // Fill part of a full-length ring, then shorten the window below the write position.
    set_window(5'd16);
    for (int i = 0; i < 6; i++) send_sample(3'd3, (i % 2) ? SAMPLE_MIN : SAMPLE_MAX);
    set_window(5'd4);
    send_sample(3'd3, 24'sd5);
    send_sample(3'd3, 24'sd7);

    // A window of one passes samples through.
    set_window(5'd1);
    send_sample(3'd4, SAMPLE_MIN);
    send_sample(3'd4, SAMPLE_MAX);

    // A zero window flags the result invalid.
    set_window(5'd0);
    send_sample(3'd5, SAMPLE_MAX);
    send_sample(3'd0, 24'sd0);

    // Lengths above the ring size saturate.
    set_window(5'd31);
    send_sample(3'd6, SAMPLE_MAX);
    send_sample(3'd6, SAMPLE_MIN);

    // Random phases over a spread of window lengths; state carries across phases.
    phase_windows = '{5'd16, 5'd2, 5'd3, 5'd31, 5'd1, 5'd0, 5'd7, 5'd17, 5'd4,
                      5'(($urandom_range(31))), 5'd13, 5'd8};
    for (int p = 0; p < 12; p++) begin
      set_window(phase_windows[p]);
      if (p == 2) long_hold_req = 1'b1;
      if (p >= 10) no_idle = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Some phases stay on two channels so their rings fill and wrap.
        ch = (p % 3 == 1) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
        send_sample(ch, pick_sample());
      end
    end

    // Let the last averages come back, then allow for trailing work.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending_averages.size() != 0) begin
      $error("%0d averages never arrived", tracker.pending_averages.size());
      tracker.errors++;
    end

    $display("Covered %0d requests and %0d averages over %0d window writes, lengths 0 to 31.",
             requests_seen, averages_seen, windows_written);
    $display("Zero-window requests: %0d, window-of-one requests: %0d, errors: %0d.",
             tracker.zero_window_hits, tracker.single_window_hits, tracker.errors);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
hdl/mma_pkg.sv
hdl/mma_if.sv
hdl/mma_ctrl.sv
hdl/mma_datapath.sv
hdl/multichannel_moving_average.sv
dv/tb_multichannel_moving_average.sv
